// ----- rtl/core/hrp_pkg.sv -----
package hrp_pkg;

   // Character codes
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_0     = 8'h30;
   localparam logic [7:0] CHAR_9     = 8'h39;
   localparam logic [7:0] CHAR_UC_A  = 8'h41;
   localparam logic [7:0] CHAR_UC_F  = 8'h46;
   localparam logic [7:0] CHAR_LC_A  = 8'h61;
   localparam logic [7:0] CHAR_LC_F  = 8'h66;

   // Record layout: colon, length, address, type, data, checksum
   localparam int MIN_RECORD_CHARS = 11;
   localparam int POS_LENGTH       = 2;
   localparam int POS_ADDR_HI      = 4;
   localparam int POS_ADDR_LO      = 6;
   localparam int POS_TYPE         = 8;
   localparam int POS_HEADER_END   = 9;
   localparam int POS_DATA_START   = 10;

   localparam logic [23:0] TOTAL_MAX = 24'hFFFFFF;

   typedef enum logic [1:0] {
      KIND_DATA   = 2'd0,
      KIND_ACCEPT = 2'd1,
      KIND_REJECT = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ERR_NONE      = 3'd0,
      ERR_SHORT     = 3'd1,
      ERR_NO_COLON  = 3'd2,
      ERR_TRUNCATED = 3'd3,
      ERR_BAD_DIGIT = 3'd4,
      ERR_TOO_LONG  = 3'd5
   } err_type;

   typedef struct packed {
      logic       is_space;
      logic       is_colon;
      logic       hex_ok;
      logic [3:0] nibble;
   } char_class_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  byte_value;
      logic [7:0]  data_index;
      logic [15:0] record_address;
      logic [7:0]  record_length;
      logic [7:0]  record_type;
      err_type     error_code;
      logic [23:0] total_bytes;
      logic [15:0] base_address;
   } rsp_type;

endpackage

// ----- rtl/core/hrp_char_class.sv -----
// Classifies one character: whitespace, colon, hex digit value.
module hrp_char_class (
   input  logic [7:0]              char_in,
   output hrp_pkg::char_class_type cls
);

   always_comb begin
      cls.is_space = (char_in == hrp_pkg::CHAR_SPACE) || (char_in == hrp_pkg::CHAR_TAB) ||
                     (char_in == hrp_pkg::CHAR_CR)    || (char_in == hrp_pkg::CHAR_LF);
      cls.is_colon = (char_in == hrp_pkg::CHAR_COLON);
      cls.hex_ok   = 1'b1;
      cls.nibble   = 4'd0;
      priority if (char_in >= hrp_pkg::CHAR_0 && char_in <= hrp_pkg::CHAR_9) begin
         cls.nibble = 4'(char_in - hrp_pkg::CHAR_0);
      end else if (char_in >= hrp_pkg::CHAR_UC_A && char_in <= hrp_pkg::CHAR_UC_F) begin
         cls.nibble = 4'(char_in - hrp_pkg::CHAR_UC_A + 8'd10);
      end else if (char_in >= hrp_pkg::CHAR_LC_A && char_in <= hrp_pkg::CHAR_LC_F) begin
         cls.nibble = 4'(char_in - hrp_pkg::CHAR_LC_A + 8'd10);
      end else begin
         cls.hex_ok = 1'b0;
      end
   end

endmodule

// ----- rtl/core/hrp_record.sv -----
// Per-record parse state and running totals; forms the result of one character.
module hrp_record #(
   parameter int MAX_LINE_CHARS = 256
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  hrp_pkg::char_class_type cls,
   output logic                    produce,
   output hrp_pkg::rsp_type        result
);

   localparam int PW = $clog2(MAX_LINE_CHARS + 1);
   localparam int CW = (PW > 10) ? PW : 10;
   localparam logic [PW-1:0] POS_MAX  = PW'(MAX_LINE_CHARS);
   localparam logic [PW-1:0] POS_LAST = PW'(MAX_LINE_CHARS - 1);

   logic [PW-1:0]    pos_ff, pos_in;
   logic             in_record_ff, in_record_in;
   logic [3:0]       high_ff, high_in;
   logic [7:0]       len_ff, len_in;
   logic [15:0]      addr_ff, addr_in;
   logic [7:0]       type_ff, type_in;
   logic [7:0]       cksum_ff, cksum_in;
   hrp_pkg::err_type perr_ff, perr_in;
   logic [23:0]      total_ff, total_in;
   logic [15:0]      first_addr_ff, first_addr_in;
   logic             have_first_ff, have_first_in;

   logic [PW-1:0]    cur_pos;
   logic [3:0]       cur_high;
   logic [7:0]       cur_len;
   logic [15:0]      cur_addr;
   logic [7:0]       cur_type;
   logic [7:0]       cur_cksum;
   hrp_pkg::err_type cur_perr;
   logic [CW-1:0]    pos_ext;
   logic [CW-1:0]    need;
   logic [CW-1:0]    data_off;
   logic [7:0]       full_byte;
   logic [24:0]      sum;

   always_comb begin
      // a character outside a record starts from cleared record state
      cur_pos   = in_record_ff ? pos_ff   : '0;
      cur_high  = in_record_ff ? high_ff  : 4'd0;
      cur_len   = in_record_ff ? len_ff   : 8'd0;
      cur_addr  = in_record_ff ? addr_ff  : 16'd0;
      cur_type  = in_record_ff ? type_ff  : 8'd0;
      cur_cksum = in_record_ff ? cksum_ff : 8'd0;
      cur_perr  = in_record_ff ? perr_ff  : hrp_pkg::ERR_NONE;

      pos_ext   = CW'(cur_pos);
      need      = CW'({cur_len, 1'b0}) + CW'(hrp_pkg::MIN_RECORD_CHARS);
      data_off  = pos_ext - CW'(hrp_pkg::POS_DATA_START);
      full_byte = {cur_high, cls.nibble};
      sum       = {1'b0, total_ff} + {17'd0, cur_len};

      pos_in        = cur_pos;
      in_record_in  = 1'b1;
      high_in       = cur_high;
      len_in        = cur_len;
      addr_in       = cur_addr;
      type_in       = cur_type;
      cksum_in      = cur_cksum;
      perr_in       = cur_perr;
      total_in      = total_ff;
      first_addr_in = first_addr_ff;
      have_first_in = have_first_ff;

      produce               = 1'b0;
      result.kind           = hrp_pkg::KIND_DATA;
      result.byte_value     = 8'd0;
      result.data_index     = 8'd0;
      result.error_code     = hrp_pkg::ERR_NONE;

      if (cls.is_space) begin
         // end of record: clear it and report once
         in_record_in = 1'b0;
         pos_in       = '0;
         high_in      = 4'd0;
         len_in       = 8'd0;
         addr_in      = 16'd0;
         type_in      = 8'd0;
         cksum_in     = 8'd0;
         perr_in      = hrp_pkg::ERR_NONE;
         if (in_record_ff) begin
            produce     = 1'b1;
            result.kind = hrp_pkg::KIND_REJECT;
            priority if (pos_ext < CW'(hrp_pkg::MIN_RECORD_CHARS)) begin
               result.error_code = hrp_pkg::ERR_SHORT;
            end else if (cur_perr != hrp_pkg::ERR_NONE) begin
               result.error_code = cur_perr;
            end else if (pos_ext < need) begin
               result.error_code = hrp_pkg::ERR_TRUNCATED;
            end else begin
               result.kind       = hrp_pkg::KIND_ACCEPT;
               result.byte_value = cur_cksum;
               total_in          = sum[24] ? hrp_pkg::TOTAL_MAX : sum[23:0];
               if (!have_first_ff) begin
                  first_addr_in = cur_addr;
                  have_first_in = 1'b1;
               end
            end
         end
      end else if (cur_pos >= POS_LAST) begin
         // overlong line: count up to the limit, decode nothing more
         if (cur_perr == hrp_pkg::ERR_NONE) begin
            perr_in = hrp_pkg::ERR_TOO_LONG;
         end
         if (cur_pos < POS_MAX) begin
            pos_in = cur_pos + 1'b1;
         end
      end else begin
         pos_in = cur_pos + 1'b1;
         if (cur_pos == '0) begin
            if (!cls.is_colon && cur_perr == hrp_pkg::ERR_NONE) begin
               perr_in = hrp_pkg::ERR_NO_COLON;
            end
         end else if (!(pos_ext >= CW'(hrp_pkg::POS_HEADER_END) && pos_ext >= need)) begin
            if (!cls.hex_ok && cur_perr == hrp_pkg::ERR_NONE) begin
               perr_in = hrp_pkg::ERR_BAD_DIGIT;
            end
            if (cur_pos[0]) begin
               high_in = cls.nibble;
            end else if (pos_ext == CW'(hrp_pkg::POS_LENGTH)) begin
               len_in = full_byte;
            end else if (pos_ext == CW'(hrp_pkg::POS_ADDR_HI)) begin
               addr_in = {full_byte, cur_addr[7:0]};
            end else if (pos_ext == CW'(hrp_pkg::POS_ADDR_LO)) begin
               addr_in = {cur_addr[15:8], full_byte};
            end else if (pos_ext == CW'(hrp_pkg::POS_TYPE)) begin
               type_in = full_byte;
            end else if (pos_ext == need - 1'b1) begin
               cksum_in = full_byte;
            end else if (perr_in == hrp_pkg::ERR_NONE) begin
               produce           = 1'b1;
               result.byte_value = full_byte;
               result.data_index = data_off[8:1];
            end
         end
      end

      result.record_address = cur_addr;
      result.record_length  = cur_len;
      result.record_type    = cur_type;
      result.total_bytes    = total_in;
      result.base_address   = first_addr_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= '0;
         in_record_ff  <= 1'b0;
         high_ff       <= 4'd0;
         len_ff        <= 8'd0;
         addr_ff       <= 16'd0;
         type_ff       <= 8'd0;
         cksum_ff      <= 8'd0;
         perr_ff       <= hrp_pkg::ERR_NONE;
         total_ff      <= 24'd0;
         first_addr_ff <= 16'd0;
         have_first_ff <= 1'b0;
      end else if (step) begin
         pos_ff        <= pos_in;
         in_record_ff  <= in_record_in;
         high_ff       <= high_in;
         len_ff        <= len_in;
         addr_ff       <= addr_in;
         type_ff       <= type_in;
         cksum_ff      <= cksum_in;
         perr_ff       <= perr_in;
         total_ff      <= total_in;
         first_addr_ff <= first_addr_in;
         have_first_ff <= have_first_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_idle_cleared: assert property (@(posedge clock) disable iff (reset)
      !in_record_ff |-> (pos_ff == '0) && (perr_ff == hrp_pkg::ERR_NONE))
      else $error("record state not cleared outside a record");
   a_pos_bounded: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_MAX)
      else $error("character position beyond line limit");
`endif

endmodule

// ----- rtl/core/hrp_rsp_buffer.sv -----
// Output register: holds one result beat until the receiver takes it.
module hrp_rsp_buffer (
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  hrp_pkg::rsp_type rsp_in,
   input  logic             rsp_ready,
   output logic             rsp_valid,
   output logic             space,
   output hrp_pkg::rsp_type rsp_out
);

   logic             valid_ff, valid_in;
   hrp_pkg::rsp_type data_ff;

   // room for a new beat when empty or when the held one leaves this cycle
   assign space     = !valid_ff || rsp_ready;
   assign rsp_valid = valid_ff;
   assign rsp_out   = data_ff;

   always_comb begin
      valid_in = valid_ff && !rsp_ready;
      if (load) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= rsp_in;
      end
   end

endmodule

// ----- rtl/core/hex_record_parser.sv -----
// Streaming hex-record text parser.
// Input channel (req_): one character per beat on req_char_in. Space, tab, CR
// and LF end a record; a record opens with ':' followed by hex pairs for
// length, address, type, data bytes and checksum.
// Result channel (rsp_): at most one beat per character. A data byte beat
// (kind 0) leaves when its second digit arrives, unless a fault is pending;
// the whitespace that ends a record gives one beat that accepts (kind 1) or
// rejects (kind 2, with error_code) the record. Every beat carries the
// record's fields, the saturating byte total and the first accepted address.
// Latency: a result beat is valid the cycle after its character is accepted.
// Throughput: one character per cycle; the record state updates in a single
// pass between the input handshake and the output register.
// Stall: while a result beat waits on rsp_ready low, req_ready drops; a
// character that produces no beat still needs that register free.
// Reset (synchronous, active high) clears the record, the totals and the
// output register; the block takes characters in the next cycle.
module hex_record_parser #(
   parameter int MAX_LINE_CHARS = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_char_in,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_byte_value,
   output logic [7:0]  rsp_data_index,
   output logic [15:0] rsp_record_address,
   output logic [7:0]  rsp_record_length,
   output logic [7:0]  rsp_record_type,
   output logic [2:0]  rsp_error_code,
   output logic [23:0] rsp_total_bytes,
   output logic [15:0] rsp_base_address
);

   hrp_pkg::char_class_type cls;
   hrp_pkg::rsp_type        result;
   hrp_pkg::rsp_type        rsp_data;
   logic                    produce;
   logic                    space;
   logic                    accept;

   assign req_ready = space;
   assign accept    = req_valid && req_ready;

   // character decode
   hrp_char_class u_class (
      .char_in (req_char_in),
      .cls     (cls)
   );

   // record state; advances on each accepted character
   hrp_record #(
      .MAX_LINE_CHARS (MAX_LINE_CHARS)
   ) u_record (
      .clock   (clock),
      .reset   (reset),
      .step    (accept),
      .cls     (cls),
      .produce (produce),
      .result  (result)
   );

   // result beat register
   hrp_rsp_buffer u_rsp (
      .clock     (clock),
      .reset     (reset),
      .load      (accept && produce),
      .rsp_in    (result),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .space     (space),
      .rsp_out   (rsp_data)
   );

   assign rsp_kind           = rsp_data.kind;
   assign rsp_byte_value     = rsp_data.byte_value;
   assign rsp_data_index     = rsp_data.data_index;
   assign rsp_record_address = rsp_data.record_address;
   assign rsp_record_length  = rsp_data.record_length;
   assign rsp_record_type    = rsp_data.record_type;
   assign rsp_error_code     = rsp_data.error_code;
   assign rsp_total_bytes    = rsp_data.total_bytes;
   assign rsp_base_address   = rsp_data.base_address;

`ifndef NO_ASSERTIONS
   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("input taken while result beat is stalled");
   a_data_no_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind != hrp_pkg::KIND_REJECT |->
      rsp_data.error_code == hrp_pkg::ERR_NONE)
      else $error("error code on a data or accept beat");
   a_reject_has_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind == hrp_pkg::KIND_REJECT |->
      rsp_data.error_code != hrp_pkg::ERR_NONE)
      else $error("reject beat without an error code");
   a_beat_follows_work: assert property (@(posedge clock) disable iff (reset)
      accept && produce |=> rsp_valid)
      else $error("result beat lost");
`endif

endmodule

// ----- dv/tb_hex_record_parser.sv -----
`timescale 1ns / 1ps

module tb_hex_record_parser;

   localparam int LINE_CHARS   = 256;   // matches the block's default line limit
   localparam int IDLE_PCT     = 31;    // chance per cycle that a side sits idle
   localparam int HOLD_AT      = 780;   // characters taken before the long result stall
   localparam int HOLD_CYCLES  = 400;
   localparam int CALM_FROM    = 150;   // window with no random idling on either side
   localparam int CALM_TO      = 450;
   localparam int CHAR_BUDGET  = 1000;  // characters sent at the least, directed rows included
   localparam int STALL_LIMIT  = 2000;  // cycles with no beat on either side

   // One character on its way to the block. Closing characters of directed rows
   // may carry a typed verdict that overrides the predicted kind and error code.
   typedef struct packed {
      logic [7:0]        ch;
      logic              pinned;
      hrp_pkg::kind_type kind;
      hrp_pkg::err_type  err;
   } char_item_type;

   typedef struct {
      string             text;
      logic [7:0]        term;
      bit                pinned;
      hrp_pkg::kind_type kind;
      hrp_pkg::err_type  err;
   } row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_char_in = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_kind;
   logic [7:0]  rsp_byte_value;
   logic [7:0]  rsp_data_index;
   logic [15:0] rsp_record_address;
   logic [7:0]  rsp_record_length;
   logic [7:0]  rsp_record_type;
   logic [2:0]  rsp_error_code;
   logic [23:0] rsp_total_bytes;
   logic [15:0] rsp_base_address;

   hex_record_parser uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_char_in        (req_char_in),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_kind           (rsp_kind),
      .rsp_byte_value     (rsp_byte_value),
      .rsp_data_index     (rsp_data_index),
      .rsp_record_address (rsp_record_address),
      .rsp_record_length  (rsp_record_length),
      .rsp_record_type    (rsp_record_type),
      .rsp_error_code     (rsp_error_code),
      .rsp_total_bytes    (rsp_total_bytes),
      .rsp_base_address   (rsp_base_address)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Parser shadow state
   // ------------------------------------------------------------------
   int               rec_pos;      // characters seen in the open record, saturating
   bit               in_rec;
   logic [3:0]       hi_nib;
   logic [7:0]       len_f;
   logic [15:0]      addr_f;
   logic [7:0]       type_f;
   logic [7:0]       csum_f;
   hrp_pkg::err_type fault;        // first fault of the open record
   logic [23:0]      byte_sum;
   logic [15:0]      first_addr;
   bit               got_first;

   // Bookkeeping
   char_item_type    char_stream[$];
   hrp_pkg::rsp_type pending_beats[$];
   char_item_type    on_wire;
   char_item_type    next_item;
   logic [7:0]       rec_buf[$];
   row_type          rows[$];
   int               chars_queued = 0;
   int               chars_taken = 0;
   int               mismatches = 0;
   int               data_seen = 0;
   int               accepts_seen = 0;
   int               rejects_seen = 0;
   int               quiet_cycles = 0;
   bit               hold_rsp = 1'b0;
   bit               calm;
   bit               has_beat;
   hrp_pkg::rsp_type want;
   hrp_pkg::rsp_type got;

   function automatic bit is_ws(input logic [7:0] c);
      return c == hrp_pkg::CHAR_SPACE || c == hrp_pkg::CHAR_TAB ||
             c == hrp_pkg::CHAR_CR || c == hrp_pkg::CHAR_LF;
   endfunction

   function automatic bit hex_nib(input logic [7:0] c, output logic [3:0] v);
      v = 4'h0;
      if (c >= hrp_pkg::CHAR_0 && c <= hrp_pkg::CHAR_9) begin
         v = 4'(c - hrp_pkg::CHAR_0);
         return 1'b1;
      end
      if (c >= hrp_pkg::CHAR_UC_A && c <= hrp_pkg::CHAR_UC_F) begin
         v = 4'(c - hrp_pkg::CHAR_UC_A + 8'd10);
         return 1'b1;
      end
      if (c >= hrp_pkg::CHAR_LC_A && c <= hrp_pkg::CHAR_LC_F) begin
         v = 4'(c - hrp_pkg::CHAR_LC_A + 8'd10);
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic void clear_rec();
      rec_pos = 0;
      in_rec  = 1'b0;
      hi_nib  = '0;
      len_f   = '0;
      addr_f  = '0;
      type_f  = '0;
      csum_f  = '0;
      fault   = hrp_pkg::ERR_NONE;
   endfunction

   function automatic void note_fault(input hrp_pkg::err_type e);
      if (fault == hrp_pkg::ERR_NONE) fault = e;
   endfunction

   // Result beat built from the current record fields and totals.
   function automatic hrp_pkg::rsp_type make_beat(input hrp_pkg::kind_type k,
                                                  input logic [7:0] v,
                                                  input logic [7:0] idx,
                                                  input hrp_pkg::err_type e);
      hrp_pkg::rsp_type r;
      r.kind           = k;
      r.byte_value     = v;
      r.data_index     = idx;
      r.record_address = addr_f;
      r.record_length  = len_f;
      r.record_type    = type_f;
      r.error_code     = e;
      r.total_bytes    = byte_sum;
      r.base_address   = first_addr;
      return r;
   endfunction

   // Advance the shadow parser by one character; has is set when it yields a beat.
   task automatic parse_char(input logic [7:0] c, output bit has,
                             output hrp_pkg::rsp_type r);
      int          pos;
      int          need;
      logic [3:0]  nib;
      logic [7:0]  b;
      logic [24:0] sum;
      bit          ok;
      has = 1'b0;
      r   = '0;
      if (is_ws(c)) begin
         if (!in_rec) return;   // whitespace between records is ignored
         need = int'(len_f) * 2 + hrp_pkg::MIN_RECORD_CHARS;
         has  = 1'b1;
         if (rec_pos < hrp_pkg::MIN_RECORD_CHARS) begin
            r = make_beat(hrp_pkg::KIND_REJECT, 8'h00, 8'h00, hrp_pkg::ERR_SHORT);
         end else if (fault != hrp_pkg::ERR_NONE) begin
            r = make_beat(hrp_pkg::KIND_REJECT, 8'h00, 8'h00, fault);
         end else if (rec_pos < need) begin
            r = make_beat(hrp_pkg::KIND_REJECT, 8'h00, 8'h00, hrp_pkg::ERR_TRUNCATED);
         end else begin
            sum = {1'b0, byte_sum} + 25'(len_f);
            byte_sum = sum[24] ? hrp_pkg::TOTAL_MAX : sum[23:0];
            if (!got_first) begin
               first_addr = addr_f;
               got_first  = 1'b1;
            end
            r = make_beat(hrp_pkg::KIND_ACCEPT, csum_f, 8'h00, hrp_pkg::ERR_NONE);
         end
         clear_rec();
         return;
      end

      if (!in_rec) begin
         clear_rec();
         in_rec = 1'b1;
      end
      pos = rec_pos;
      // line limit reached: nothing more is decoded
      if (pos >= LINE_CHARS - 1) begin
         note_fault(hrp_pkg::ERR_TOO_LONG);
         if (rec_pos < LINE_CHARS) rec_pos++;
         return;
      end
      rec_pos++;
      if (pos == 0) begin
         if (c != hrp_pkg::CHAR_COLON) note_fault(hrp_pkg::ERR_NO_COLON);
         return;
      end
      need = int'(len_f) * 2 + hrp_pkg::MIN_RECORD_CHARS;
      if (pos >= hrp_pkg::POS_HEADER_END && pos >= need) return;   // trailing junk

      ok = hex_nib(c, nib);
      if (!ok) note_fault(hrp_pkg::ERR_BAD_DIGIT);
      if (pos % 2 == 1) begin
         hi_nib = nib;
         return;
      end
      b = {hi_nib, nib};
      if (pos == hrp_pkg::POS_LENGTH) len_f = b;
      else if (pos == hrp_pkg::POS_ADDR_HI) addr_f[15:8] = b;
      else if (pos == hrp_pkg::POS_ADDR_LO) addr_f[7:0] = b;
      else if (pos == hrp_pkg::POS_TYPE) type_f = b;
      else if (pos == need - 1) csum_f = b;
      else if (fault == hrp_pkg::ERR_NONE) begin
         r   = make_beat(hrp_pkg::KIND_DATA, b,
                         8'((pos - hrp_pkg::POS_DATA_START) / 2), hrp_pkg::ERR_NONE);
         has = 1'b1;
      end
   endtask

   // ------------------------------------------------------------------
   // Stimulus building
   // ------------------------------------------------------------------
   task automatic queue_char(input logic [7:0] c, input bit pin,
                             input hrp_pkg::kind_type k, input hrp_pkg::err_type e);
      char_item_type it;
      it.ch     = c;
      it.pinned = pin;
      it.kind   = k;
      it.err    = e;
      char_stream.push_back(it);
      chars_queued++;
   endtask

   function automatic string repeat_str(input string unit, input int n);
      string s;
      s = "";
      for (int i = 0; i < n; i++) s = {s, unit};
      return s;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
      if (n < 4'd10) return hrp_pkg::CHAR_0 + 8'(n);
      return (lower ? hrp_pkg::CHAR_LC_A : hrp_pkg::CHAR_UC_A) + 8'(n) - 8'd10;
   endfunction

   function automatic void add_hex(input logic [7:0] b, input bit lower);
      rec_buf.push_back(hex_char(b[7:4], lower));
      rec_buf.push_back(hex_char(b[3:0], lower));
   endfunction

   // Any character that does not end a record, optionally excluding hex digits.
   function automatic logic [7:0] stray_char(input bit allow_hex);
      logic [7:0] c;
      logic [3:0] unused;
      do c = 8'($urandom_range(0, 255));
      while (is_ws(c) || (!allow_hex && hex_nib(c, unused)));
      return c;
   endfunction

   function automatic logic [7:0] pick_ws();
      case ($urandom_range(0, 3))
         0: return hrp_pkg::CHAR_SPACE;
         1: return hrp_pkg::CHAR_TAB;
         2: return hrp_pkg::CHAR_CR;
         default: return hrp_pkg::CHAR_LF;
      endcase
   endfunction

   // One random record: mostly well formed with random content, the rest
   // damaged (cut short, bad digit, wrong lead, trailing junk, raw noise, overlong).
   task automatic gen_record();
      int         len;
      int         cut;
      int         p;
      int         n;
      bit         lower;
      logic [7:0] c;
      rec_buf.delete();
      lower = $urandom_range(0, 1);
      len   = ($urandom_range(0, 19) == 0) ? $urandom_range(17, 130) : $urandom_range(0, 16);
      rec_buf.push_back(hrp_pkg::CHAR_COLON);
      add_hex(8'(len), lower);
      add_hex(8'($urandom_range(0, 255)), lower);
      add_hex(8'($urandom_range(0, 255)), lower);
      add_hex(($urandom_range(0, 9) < 8) ? 8'($urandom_range(0, 5))
                                         : 8'($urandom_range(0, 255)), lower);
      for (int i = 0; i < len; i++) add_hex(8'($urandom_range(0, 255)), lower);
      add_hex(8'($urandom_range(0, 255)), lower);

      if ($urandom_range(0, 99) >= 70) begin
         case ($urandom_range(0, 5))
            0: begin
               cut = $urandom_range(1, rec_buf.size() - 1);
               while (rec_buf.size() > cut) void'(rec_buf.pop_back());
            end
            1: begin
               p = $urandom_range(1, rec_buf.size() - 1);
               rec_buf[p] = stray_char(1'b0);
            end
            2: begin
               do c = stray_char(1'b1);
               while (c == hrp_pkg::CHAR_COLON);
               rec_buf[0] = c;
            end
            3: begin
               n = $urandom_range(1, 6);
               repeat (n) rec_buf.push_back(stray_char(1'b1));
            end
            4: begin
               rec_buf.delete();
               n = $urandom_range(1, 20);
               repeat (n) rec_buf.push_back(8'($urandom_range(0, 255)));
            end
            default: begin
               if ($urandom_range(0, 3) == 0) begin
                  while (rec_buf.size() < LINE_CHARS + 4)
                     rec_buf.push_back(hex_char(4'($urandom_range(0, 15)), lower));
               end else begin
                  p = $urandom_range(1, rec_buf.size() - 1);
                  rec_buf[p] = stray_char(1'b0);
               end
            end
         endcase
      end

      foreach (rec_buf[i])
         queue_char(rec_buf[i], 1'b0, hrp_pkg::KIND_DATA, hrp_pkg::ERR_NONE);
      queue_char(pick_ws(), 1'b0, hrp_pkg::KIND_DATA, hrp_pkg::ERR_NONE);
      if ($urandom_range(0, 4) == 0) begin
         n = $urandom_range(1, 3);
         repeat (n) queue_char(pick_ws(), 1'b0, hrp_pkg::KIND_DATA, hrp_pkg::ERR_NONE);
      end
   endtask

   // ------------------------------------------------------------------
   // Drivers
   // ------------------------------------------------------------------
   // Both sides run without idling inside the calm window.
   assign calm = chars_taken >= CALM_FROM && chars_taken < CALM_TO;

   // Character sender: a new beat is offered only once the current one is taken.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (char_stream.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
            next_item = char_stream.pop_front();
            req_valid   <= 1'b1;
            req_char_in <= next_item.ch;
            on_wire     <= next_item;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result receiver: random back-pressure plus one long hold-off.
   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= !hold_rsp && (calm || $urandom_range(0, 99) >= IDLE_PCT);
   end

   // Long stall on the result side while characters keep coming, so the
   // output register fills and req_ready must drop.
   initial begin
      while (chars_taken < HOLD_AT) @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   // ------------------------------------------------------------------
   // Monitor and checker
   // ------------------------------------------------------------------
   task automatic check_field(input string name, input logic [23:0] want_v,
                              input logic [23:0] got_v);
      if (want_v !== got_v) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want_v, got_v);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         // retire the result beat first, then predict from the character beat
         if (rsp_valid && rsp_ready) begin
            if (pending_beats.size() == 0) begin
               $display("%0t: result beat with nothing expected, kind %0d", $time, rsp_kind);
               mismatches++;
            end else begin
               want = pending_beats.pop_front();
               got.kind           = hrp_pkg::kind_type'(rsp_kind);
               got.byte_value     = rsp_byte_value;
               got.data_index     = rsp_data_index;
               got.record_address = rsp_record_address;
               got.record_length  = rsp_record_length;
               got.record_type    = rsp_record_type;
               got.error_code     = hrp_pkg::err_type'(rsp_error_code);
               got.total_bytes    = rsp_total_bytes;
               got.base_address   = rsp_base_address;
               check_field("kind", want.kind, got.kind);
               check_field("byte_value", want.byte_value, got.byte_value);
               check_field("data_index", want.data_index, got.data_index);
               check_field("record_address", want.record_address, got.record_address);
               check_field("record_length", want.record_length, got.record_length);
               check_field("record_type", want.record_type, got.record_type);
               check_field("error_code", want.error_code, got.error_code);
               check_field("total_bytes", want.total_bytes, got.total_bytes);
               check_field("base_address", want.base_address, got.base_address);
               case (want.kind)
                  hrp_pkg::KIND_DATA:   data_seen++;
                  hrp_pkg::KIND_ACCEPT: accepts_seen++;
                  default:              rejects_seen++;
               endcase
            end
         end
         if (req_valid && req_ready) begin
            parse_char(req_char_in, has_beat, want);
            // directed rows state the verdict of their closing character outright
            if (on_wire.pinned) begin
               want.kind       = on_wire.kind;
               want.error_code = on_wire.err;
               has_beat        = 1'b1;
            end
            if (has_beat) pending_beats.push_back(want);
            chars_taken <= chars_taken + 1;
         end
      end
   end

   // Watchdog: any beat on either side restarts the count.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: no beat for %0d cycles, %0d results outstanding",
                  $time, quiet_cycles, pending_beats.size());
         $display("** hex_record_parser: FAILED **");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      clear_rec();
      byte_sum   = '0;
      first_addr = '0;
      got_first  = 1'b0;

      // Directed rows: text, closing whitespace, and a typed verdict where it is obvious.
      rows.push_back('{"", hrp_pkg::CHAR_LF, 1'b0, hrp_pkg::KIND_DATA,
                       hrp_pkg::ERR_NONE});                             // lone whitespace
      rows.push_back('{":00FFFFFF00", hrp_pkg::CHAR_SPACE, 1'b1, hrp_pkg::KIND_ACCEPT,
                       hrp_pkg::ERR_NONE});                             // first record
      rows.push_back('{":00000001FF", hrp_pkg::CHAR_LF, 1'b1, hrp_pkg::KIND_ACCEPT,
                       hrp_pkg::ERR_NONE});
      rows.push_back('{":10010000214601360121470136007EFE09D2190140", hrp_pkg::CHAR_CR,
                       1'b0, hrp_pkg::KIND_DATA, hrp_pkg::ERR_NONE});
      rows.push_back('{":03ffffaaabcdef12", hrp_pkg::CHAR_TAB, 1'b0, hrp_pkg::KIND_DATA,
                       hrp_pkg::ERR_NONE});                             // lower case
      rows.push_back('{":0", hrp_pkg::CHAR_SPACE, 1'b1, hrp_pkg::KIND_REJECT,
                       hrp_pkg::ERR_SHORT});
      rows.push_back('{":G", hrp_pkg::CHAR_SPACE, 1'b1, hrp_pkg::KIND_REJECT,
                       hrp_pkg::ERR_SHORT});                            // short wins
      rows.push_back('{"X00000001FF", hrp_pkg::CHAR_SPACE, 1'b1, hrp_pkg::KIND_REJECT,
                       hrp_pkg::ERR_NO_COLON});
      rows.push_back('{"X0G000001FF", hrp_pkg::CHAR_LF, 1'b1, hrp_pkg::KIND_REJECT,
                       hrp_pkg::ERR_NO_COLON});                         // first fault
      rows.push_back('{":02000000AB", hrp_pkg::CHAR_TAB, 1'b1, hrp_pkg::KIND_REJECT,
                       hrp_pkg::ERR_TRUNCATED});
      rows.push_back('{":02000000FFEEZZ", hrp_pkg::CHAR_SPACE, 1'b1, hrp_pkg::KIND_REJECT,
                       hrp_pkg::ERR_BAD_DIGIT});
      rows.push_back('{":00000001FFjunk!", hrp_pkg::CHAR_CR, 1'b1, hrp_pkg::KIND_ACCEPT,
                       hrp_pkg::ERR_NONE});                             // tail ignored
      // longest record that fits the line, then one byte more
      rows.push_back('{{":7A000000", repeat_str("A5", 122), "00"}, hrp_pkg::CHAR_LF,
                       1'b1, hrp_pkg::KIND_ACCEPT, hrp_pkg::ERR_NONE});
      rows.push_back('{{":7B000000", repeat_str("5a", 123), "00"}, hrp_pkg::CHAR_LF,
                       1'b1, hrp_pkg::KIND_REJECT, hrp_pkg::ERR_TOO_LONG});
      rows.push_back('{{":FF123456", repeat_str("00", 8)}, hrp_pkg::CHAR_TAB,
                       1'b1, hrp_pkg::KIND_REJECT, hrp_pkg::ERR_TRUNCATED});

      foreach (rows[r]) begin
         for (int i = 0; i < rows[r].text.len(); i++)
            queue_char(rows[r].text[i], 1'b0, hrp_pkg::KIND_DATA, hrp_pkg::ERR_NONE);
         queue_char(rows[r].term, rows[r].pinned, rows[r].kind, rows[r].err);
      end

      // random records until the character budget is spent
      while (chars_queued < CHAR_BUDGET) gen_record();

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (chars_taken != chars_queued) @(posedge clock);
      while (pending_beats.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);

      $display("Sent %0d characters through directed and random records", chars_queued);
      $display("Checked %0d data bytes, %0d accepted and %0d rejected records",
               data_seen, accepts_seen, rejects_seen);
      if (mismatches == 0) begin
         $display("** hex_record_parser: PASSED **");
      end else begin
         $display("** hex_record_parser: FAILED **");
      end
      $finish;
   end

endmodule
